// ===== hw/rtl/websocket_frame_deframer_defines.svh =====
// Assertion macros used by the WebSocket deframer parser RTL.
`ifndef WEBSOCKET_FRAME_DEFRAMER_DEFINES_SVH
`define WEBSOCKET_FRAME_DEFRAMER_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define WSD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("wsd assertion failed");

// Next-cycle implication, disabled while reset is held.
`define WSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("wsd assertion failed");

`endif

// ===== hw/rtl/wsd_pkg.sv =====
// Types and constants shared by the WebSocket deframer modules.
`timescale 1ns / 1ps
package wsd_pkg;

    typedef enum logic [2:0] {
        EV_DATA  = 3'd0,
        EV_EMPTY = 3'd1,
        EV_PING  = 3'd2,
        EV_EPING = 3'd3,
        EV_PONG  = 3'd4,
        EV_CLOSE = 3'd5,
        EV_ERROR = 3'd6
    } t_event;

    typedef struct packed {
        t_event     ev;
        logic [7:0] data;
        logic       last;
    } t_result;

    localparam logic [3:0] OP_CONT  = 4'd0;
    localparam logic [3:0] OP_TEXT  = 4'd1;
    localparam logic [3:0] OP_BIN   = 4'd2;
    localparam logic [3:0] OP_CLOSE = 4'd8;
    localparam logic [3:0] OP_PING  = 4'd9;
    localparam logic [3:0] OP_PONG  = 4'd10;

    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;
    localparam logic [3:0] KEY_BYTES   = 4'd4;

endpackage

// ===== hw/rtl/websocket_frame_deframer.sv =====
// Top level of the WebSocket receive frame deframer.
`timescale 1ns / 1ps
// Usage:
// Received connection bytes enter on the s_axis channel, one byte per transfer.
// The block decodes each frame header (FIN, opcode, mask bit, 7-bit length with
// 16- or 64-bit extension, masking key) and unmasks payload bytes.
// Results leave on the m_axis channel: tdata is the unmasked byte (zero for pure
// events), tuser is the event code and tlast marks the final result of a frame.
// Final data frames and ping frames stream their payload; empty frames, pong and
// close frames and protocol errors give a single event with tlast set.
// Path: an accepted byte waits in the input register; the parser step decodes it
// and loads its result into the result register, which drives m_axis.
// Throughput: one byte per cycle while m_axis does not stall, with the parser step
// between the input register and the result register.
// When m_axis stalls, the result register holds its result and the input register
// holds one more byte; s_axis_tready drops only when both are full.
// Reset (i_rst_n low at a clock edge) empties both registers and returns the parser
// to the first header byte. After a close frame or an error the parser drops every
// byte, without a result, until the next reset.
module websocket_frame_deframer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,    // [7:0] rx_byte
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,    // [7:0] data_byte
    output logic [2:0] m_axis_tuser,    // [2:0] event_res
    output logic       m_axis_tlast     // last
);
    import wsd_pkg::*;

    logic       in_valid;
    logic [7:0] in_byte;
    logic       out_free;
    logic       step;
    logic       res_valid;
    t_result    res;
    t_result    out_res;

    // The parser advances whenever a byte waits and the result register can take
    // whatever the step produces.
    assign step = in_valid && out_free;

    wsd_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_byte  (s_axis_tdata),
        .o_valid (in_valid),
        .o_byte  (in_byte),
        .i_take  (out_free)
    );

    wsd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_byte      (in_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    wsd_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (res_valid),
        .i_res   (res),
        .o_free  (out_free),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_res   (out_res)
    );

    assign m_axis_tdata = out_res.data;
    assign m_axis_tuser = out_res.ev;
    assign m_axis_tlast = out_res.last;
endmodule

// ===== hw/rtl/wsd_in_stage.sv =====
// Input register that holds one received byte until the parser takes it.
`timescale 1ns / 1ps
module wsd_in_stage (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_byte,
    output logic       o_valid,
    output logic [7:0] o_byte,
    input  logic       i_take
);
    logic       r_valid;
    logic [7:0] r_byte;

    // The register can refill in the same cycle that it is emptied.
    assign o_ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_byte <= i_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;
endmodule

// ===== hw/rtl/wsd_parser.sv =====
// Frame header parser, payload unmasking and event generation.
`timescale 1ns / 1ps
`include "websocket_frame_deframer_defines.svh"
module wsd_parser (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_step,
    input  logic [7:0]      i_byte,
    output logic            o_res_valid,
    output wsd_pkg::t_result o_res
);
    import wsd_pkg::*;

    typedef enum logic [2:0] {
        PH_B0   = 3'd0,
        PH_B1   = 3'd1,
        PH_EXT  = 3'd2,
        PH_KEY  = 3'd3,
        PH_PAY  = 3'd4,
        PH_STOP = 3'd5
    } t_phase;

    t_phase      r_phase, n_phase;
    logic        r_fin, n_fin;
    logic [3:0]  r_kind, n_kind;
    logic        r_masked, n_masked;
    logic [3:0]  r_cnt, n_cnt;
    // Holds the length while the header is read, then counts remaining bytes.
    logic [63:0] r_len, n_len;
    logic [1:0]  r_idx, n_idx;
    logic [31:0] r_key, n_key;

    logic        after_len;
    logic        masked_now;
    logic        hdr_done;
    logic [63:0] hdr_len;
    logic [7:0]  key_byte;
    logic        lst;
    t_event      end_ev;
    logic        is_data;

    // Event given at the end of a frame that streams nothing at that point.
    function automatic t_event end_event(input logic [3:0] kind, input logic fin);
        t_event ev;
        case (kind)
            OP_CONT, OP_TEXT, OP_BIN: ev = fin ? EV_EMPTY : EV_ERROR;
            OP_PING:                  ev = EV_EPING;
            OP_PONG:                  ev = EV_PONG;
            OP_CLOSE:                 ev = EV_CLOSE;
            default:                  ev = EV_ERROR;
        endcase
        return ev;
    endfunction

    always_comb begin
        n_phase     = r_phase;
        n_fin       = r_fin;
        n_kind      = r_kind;
        n_masked    = r_masked;
        n_cnt       = r_cnt;
        n_len       = r_len;
        n_idx       = r_idx;
        n_key       = r_key;
        after_len   = 1'b0;
        masked_now  = r_masked;
        hdr_done    = 1'b0;
        hdr_len     = r_len;
        o_res_valid = 1'b0;
        o_res       = '{ev: EV_DATA, data: 8'd0, last: 1'b0};
        end_ev      = end_event(r_kind, r_fin);
        is_data     = (r_kind == OP_CONT) || (r_kind == OP_TEXT) || (r_kind == OP_BIN);
        lst         = (r_len == 64'd1);
        case (r_idx)
            2'd0:    key_byte = r_key[31:24];
            2'd1:    key_byte = r_key[23:16];
            2'd2:    key_byte = r_key[15:8];
            default: key_byte = r_key[7:0];
        endcase

        if (i_step) begin
            case (r_phase)
                PH_B0: begin
                    n_fin    = i_byte[7];
                    n_kind   = i_byte[3:0];
                    n_masked = 1'b0;
                    n_key    = 32'd0;
                    n_len    = 64'd0;
                    n_idx    = 2'd0;
                    n_cnt    = 4'd0;
                    n_phase  = PH_B1;
                end
                PH_B1: begin
                    n_masked   = i_byte[7];
                    masked_now = i_byte[7];
                    if (i_byte[6:0] == LEN_EXT16) begin
                        n_phase = PH_EXT;
                        n_cnt   = EXT16_BYTES;
                    end else if (i_byte[6:0] == LEN_EXT64) begin
                        n_phase = PH_EXT;
                        n_cnt   = EXT64_BYTES;
                    end else begin
                        hdr_len   = {57'd0, i_byte[6:0]};
                        n_len     = hdr_len;
                        after_len = 1'b1;
                    end
                end
                PH_EXT: begin
                    hdr_len   = {r_len[55:0], i_byte};
                    n_len     = hdr_len;
                    n_cnt     = r_cnt - 4'd1;
                    after_len = (n_cnt == 4'd0);
                end
                PH_KEY: begin
                    n_key    = {r_key[23:0], i_byte};
                    n_cnt    = r_cnt - 4'd1;
                    hdr_done = (n_cnt == 4'd0);
                end
                PH_PAY: begin
                    n_len = r_len - 64'd1;
                    n_idx = r_idx + 2'd1;
                    if (is_data && r_fin) begin
                        o_res_valid = 1'b1;
                        o_res       = '{ev: EV_DATA, data: i_byte ^ key_byte, last: lst};
                        if (lst) n_phase = PH_B0;
                    end else if (r_kind == OP_PING) begin
                        o_res_valid = 1'b1;
                        o_res       = '{ev: EV_PING, data: i_byte ^ key_byte, last: lst};
                        if (lst) n_phase = PH_B0;
                    end else if (lst) begin
                        o_res_valid = 1'b1;
                        o_res       = '{ev: end_ev, data: 8'd0, last: 1'b1};
                        n_phase     = (end_ev == EV_PONG) ? PH_B0 : PH_STOP;
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase

            if (after_len) begin
                if (masked_now) begin
                    n_phase = PH_KEY;
                    n_cnt   = KEY_BYTES;
                end else begin
                    hdr_done = 1'b1;
                end
            end

            if (hdr_done) begin
                n_idx = 2'd0;
                if (hdr_len == 64'd0) begin
                    o_res_valid = 1'b1;
                    o_res       = '{ev: end_ev, data: 8'd0, last: 1'b1};
                    if (end_ev == EV_CLOSE || end_ev == EV_ERROR) begin
                        n_phase = PH_STOP;
                    end else begin
                        n_phase = PH_B0;
                    end
                end else begin
                    n_phase = PH_PAY;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_B0;
            r_fin    <= 1'b0;
            r_kind   <= 4'd0;
            r_masked <= 1'b0;
            r_cnt    <= 4'd0;
            r_len    <= 64'd0;
            r_idx    <= 2'd0;
            r_key    <= 32'd0;
        end else begin
            r_phase  <= n_phase;
            r_fin    <= n_fin;
            r_kind   <= n_kind;
            r_masked <= n_masked;
            r_cnt    <= n_cnt;
            r_len    <= n_len;
            r_idx    <= n_idx;
            r_key    <= n_key;
        end
    end

    `WSD_ASSERT_NEXT(a_stop_sticks, i_clk, i_rst_n, r_phase == PH_STOP, r_phase == PH_STOP)
    `WSD_ASSERT_IMPL(a_stop_silent, i_clk, i_rst_n, r_phase == PH_STOP, !o_res_valid)
    `WSD_ASSERT_IMPL(a_event_is_last, i_clk, i_rst_n,
        o_res_valid && o_res.ev != EV_DATA && o_res.ev != EV_PING,
        o_res.last && o_res.data == 8'd0)
    `WSD_ASSERT_IMPL(a_key_only_masked, i_clk, i_rst_n, r_phase == PH_KEY, r_masked)
endmodule

// ===== hw/rtl/wsd_out_stage.sv =====
// Result register that holds one result until the downstream side takes it.
`timescale 1ns / 1ps
module wsd_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  wsd_pkg::t_result i_res,
    output logic             o_free,
    output logic             o_valid,
    input  logic             i_ready,
    output wsd_pkg::t_result o_res
);
    import wsd_pkg::*;

    logic    r_valid;
    t_result r_res;

    // A new result may enter while the held one is being transferred.
    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
        if (o_free && i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;
endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the WebSocket receive frame deframer.
`timescale 1ns / 1ps
// The testbench drives received connection bytes into the s_axis side and checks
// every m_axis transfer against a cycle-free predictor of the parser. The
// predictor runs on each input transfer and queues the events that the byte
// causes. A checker process pops one queued event per output transfer and
// compares the event code, the data byte and tlast.
//
// Test order:
//   data frames      - streamed payload with byte extremes, empty messages,
//                      a 16-bit extended length of zero
//   control frames   - empty ping, pong with reserved bits set, a masked ping
//                      without FIN that uses the 64-bit length form
//   backpressure     - the receiver holds off for a long stretch while a long,
//                      masked ping frame (over 125 bytes) is offered
//   random stream    - well-formed frames with random content and headers,
//                      under three idling patterns
//   stop conditions  - one frame that halts the parser (or leaves a frame with a
//                      huge length open), then noise bytes
//
// A close frame or a protocol error halts the parser until reset, and reset
// is applied only once, so each run ends with one such frame or a frame left
// open. Which is picked at random, so the seed decides the stop path a run covers.
module tb;
    import wsd_pkg::*;

    // Length encodings of the second header byte.
    localparam int FORM_SHORT = 0;
    localparam int FORM_EXT16 = 1;
    localparam int FORM_EXT64 = 2;

    // Ways to end the run.
    localparam int END_CLOSE      = 0;
    localparam int END_FRAGMENT   = 1;
    localparam int END_BAD_OPCODE = 2;
    localparam int END_OPEN_FRAME = 3;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_BYTES = 540;
    localparam int DRAIN_CYCLES = 8;

    // Parser phases of the predictor.
    typedef enum logic [2:0] {
        P_HDR0,
        P_HDR1,
        P_EXTLEN,
        P_KEY,
        P_PAYLOAD,
        P_HALTED
    } t_parse_phase;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'd0;   // [7:0] rx_byte
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;          // [7:0] data_byte
    logic [2:0] m_axis_tuser;          // [2:0] event_res
    logic       m_axis_tlast;          // last

    // Idle chances in percent per cycle, and the receiver hold-off counter.
    int send_idle_pct = 16;
    int recv_idle_pct = 45;
    int stall_left = 0;

    int sent_bytes = 0;
    int fault_count = 0;
    int cycle_count = 0;

    // Predictor state.
    t_parse_phase ps_phase = P_HDR0;
    logic        ps_fin = 1'b0;
    logic [3:0]  ps_op = OP_CONT;
    logic        ps_masked = 1'b0;
    logic [3:0]  ps_count = 4'd0;
    logic [63:0] ps_len = 64'd0;
    logic [63:0] ps_idx = 64'd0;
    logic [31:0] ps_key = 32'd0;

    t_result predicted_events[$];

    websocket_frame_deframer DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic logic is_data_op(logic [3:0] op);
        return op == OP_CONT || op == OP_TEXT || op == OP_BIN;
    endfunction

    function void push_event(t_event ev, logic [7:0] data, logic last);
        t_result r;
        r.ev   = ev;
        r.data = data;
        r.last = last;
        predicted_events.push_back(r);
    endfunction

    // Event at the end of a frame whose payload is not streamed: an empty frame,
    // or the final payload byte of a pong, close, fragment or unknown opcode.
    function void finish_frame();
        if (is_data_op(ps_op)) begin
            if (!ps_fin) begin
                ps_phase = P_HALTED;
                push_event(EV_ERROR, 8'd0, 1'b1);
            end else begin
                ps_phase = P_HDR0;
                push_event(EV_EMPTY, 8'd0, 1'b1);
            end
        end else if (ps_op == OP_PING) begin
            ps_phase = P_HDR0;
            push_event(EV_EPING, 8'd0, 1'b1);
        end else if (ps_op == OP_PONG) begin
            ps_phase = P_HDR0;
            push_event(EV_PONG, 8'd0, 1'b1);
        end else if (ps_op == OP_CLOSE) begin
            ps_phase = P_HALTED;
            push_event(EV_CLOSE, 8'd0, 1'b1);
        end else begin
            ps_phase = P_HALTED;
            push_event(EV_ERROR, 8'd0, 1'b1);
        end
    endfunction

    function void header_complete();
        ps_idx = 64'd0;
        if (ps_len == 64'd0) begin
            finish_frame();
        end else begin
            ps_phase = P_PAYLOAD;
        end
    endfunction

    function void length_complete();
        if (ps_masked) begin
            ps_phase = P_KEY;
            ps_count = KEY_BYTES;
        end else begin
            header_complete();
        end
    endfunction

    // Advances the parser by one received byte and queues the event it causes.
    function void parse_rx_byte(logic [7:0] b);
        logic [7:0] plain;
        logic       final_byte;
        case (ps_phase)
            P_HDR0: begin
                ps_fin    = b[7];
                ps_op     = b[3:0];
                ps_masked = 1'b0;
                ps_key    = 32'd0;
                ps_len    = 64'd0;
                ps_idx    = 64'd0;
                ps_count  = 4'd0;
                ps_phase  = P_HDR1;
            end
            P_HDR1: begin
                ps_masked = b[7];
                if (b[6:0] == LEN_EXT16) begin
                    ps_phase = P_EXTLEN;
                    ps_count = EXT16_BYTES;
                end else if (b[6:0] == LEN_EXT64) begin
                    ps_phase = P_EXTLEN;
                    ps_count = EXT64_BYTES;
                end else begin
                    ps_len = {57'd0, b[6:0]};
                    length_complete();
                end
            end
            P_EXTLEN: begin
                // The extended length arrives most significant byte first.
                ps_len   = {ps_len[55:0], b};
                ps_count = ps_count - 4'd1;
                if (ps_count == 4'd0) length_complete();
            end
            P_KEY: begin
                ps_key   = {ps_key[23:0], b};
                ps_count = ps_count - 4'd1;
                if (ps_count == 4'd0) header_complete();
            end
            P_PAYLOAD: begin
                // The first key byte received sits in the top byte of ps_key.
                plain      = b ^ ps_key[8 * (3 - ps_idx[1:0]) +: 8];
                final_byte = (ps_idx == ps_len - 64'd1);
                ps_idx     = ps_idx + 64'd1;
                if (is_data_op(ps_op) && ps_fin) begin
                    if (final_byte) ps_phase = P_HDR0;
                    push_event(EV_DATA, plain, final_byte);
                end else if (ps_op == OP_PING) begin
                    if (final_byte) ps_phase = P_HDR0;
                    push_event(EV_PING, plain, final_byte);
                end else if (final_byte) begin
                    finish_frame();
                end
            end
            default: begin
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Driving and checking
    // ------------------------------------------------------------------

    // Offers one byte, with random idle cycles first. The handshake is sampled at
    // the falling edge, so the transfer completes at the following rising edge.
    // The task is entered and left at a rising edge.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'($urandom);
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(negedge i_clk);
        while (!s_axis_tready) @(negedge i_clk);
        parse_rx_byte(b);
        sent_bytes++;
        @(posedge i_clk);
    endtask

    // Sends a frame header and then nbytes random payload bytes. nbytes may be
    // smaller than the length so that a caller can supply its own payload.
    task automatic send_frame(input logic fin, input logic [2:0] rsv, input logic [3:0] op,
                              input logic masked, input int form, input logic [63:0] len,
                              input int nbytes);
        logic [31:0] key;
        logic [6:0]  len7;
        key = $urandom;
        case (form)
            FORM_EXT16: len7 = LEN_EXT16;
            FORM_EXT64: len7 = LEN_EXT64;
            default:    len7 = len[6:0];
        endcase
        send_byte({fin, rsv, op});
        send_byte({masked, len7});
        if (form == FORM_EXT16) begin
            for (int i = 1; i >= 0; i--) send_byte(len[8 * i +: 8]);
        end else if (form == FORM_EXT64) begin
            for (int i = 7; i >= 0; i--) send_byte(len[8 * i +: 8]);
        end
        if (masked) begin
            for (int i = 3; i >= 0; i--) send_byte(key[8 * i +: 8]);
        end
        repeat (nbytes) send_byte(8'($urandom));
    endtask

    // Receiver: random ready, or held low while a hold-off is counting down.
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            m_axis_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Each output transfer is checked against the oldest predicted event.
    always @(negedge i_clk) begin
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (predicted_events.size() == 0) begin
                $error("unexpected result: event_res %0d data_byte %0h last %0b",
                       m_axis_tuser, m_axis_tdata, m_axis_tlast);
                fault_count++;
            end else begin
                want = predicted_events.pop_front();
                if (m_axis_tuser !== want.ev) begin
                    $error("event_res expected %0d got %0d", want.ev, m_axis_tuser);
                    fault_count++;
                end
                if (m_axis_tdata !== want.data) begin
                    $error("data_byte expected %0h got %0h", want.data, m_axis_tdata);
                    fault_count++;
                end
                if (m_axis_tlast !== want.last) begin
                    $error("last expected %0b got %0b", want.last, m_axis_tlast);
                    fault_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[websocket_frame_deframer] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    task automatic test_data_frames();
        // Final text frame, unmasked, with both byte extremes as payload.
        send_frame(1'b1, 3'd0, OP_TEXT, 1'b0, FORM_SHORT, 64'd2, 0);
        send_byte(8'h00);
        send_byte(8'hff);
        // Empty final continuation frame gives an empty-message event.
        send_frame(1'b1, 3'd0, OP_CONT, 1'b0, FORM_SHORT, 64'd0, 0);
        // A 16-bit extended length of zero is an empty frame as well.
        send_frame(1'b1, 3'd0, OP_BIN, 1'b0, FORM_EXT16, 64'd0, 0);
    endtask

    task automatic test_control_frames();
        send_frame(1'b1, 3'd0, OP_PING, 1'b0, FORM_SHORT, 64'd0, 0);
        // Reserved bits are ignored; the pong event comes on its only payload byte.
        send_frame(1'b1, 3'd7, OP_PONG, 1'b0, FORM_SHORT, 64'd1, 1);
        // A ping streams its payload even without FIN.
        send_frame(1'b0, 3'd0, OP_PING, 1'b1, FORM_EXT64, 64'd1, 1);
    endtask

    task automatic test_backpressure();
        // Stop offering while the hold-off is armed at the falling edge.
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        stall_left = 300;
        @(posedge i_clk);
        // Longer than 125 bytes: control frames take the length as given.
        send_frame(1'b1, 3'd0, OP_PING, 1'b1, FORM_EXT16, 64'd200, 200);
    endtask

    task automatic send_random_frame();
        logic [3:0]  op;
        logic        fin;
        logic [63:0] len;
        int          form;
        int          pick;
        pick = $urandom_range(99);
        if (pick < 60) begin
            op  = 4'($urandom_range(2));
            fin = 1'b1;
        end else if (pick < 80) begin
            op  = OP_PING;
            fin = 1'($urandom);
        end else begin
            op  = OP_PONG;
            fin = 1'($urandom);
        end
        form = FORM_SHORT;
        pick = $urandom_range(99);
        if (pick < 8) begin
            len = 64'd0;
        end else if (pick < 70) begin
            len = 64'($urandom_range(12, 1));
        end else if (pick < 85) begin
            len = 64'($urandom_range(125, 13));
        end else if (pick < 95) begin
            form = FORM_EXT16;
            len  = 64'($urandom_range(160));
        end else begin
            form = FORM_EXT64;
            len  = 64'($urandom_range(40));
        end
        send_frame(fin, 3'($urandom), op, 1'($urandom), form, len, int'(len));
    endtask

    task automatic test_random_stream();
        int goal;
        goal = sent_bytes + RANDOM_BYTES / 3;
        send_idle_pct = 16;
        recv_idle_pct = 45;
        while (sent_bytes < goal) send_random_frame();
        goal = sent_bytes + RANDOM_BYTES / 3;
        send_idle_pct = 45;
        recv_idle_pct = 16;
        while (sent_bytes < goal) send_random_frame();
        goal = sent_bytes + RANDOM_BYTES / 3;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        while (sent_bytes < goal) send_random_frame();
    endtask

    task automatic test_stop_conditions();
        logic [3:0] op;
        int         len;
        len = $urandom_range(3);
        case ($urandom_range(END_OPEN_FRAME))
            END_CLOSE: begin
                send_frame(1'b1, 3'($urandom), OP_CLOSE, 1'($urandom), FORM_SHORT,
                           64'(len), len);
            end
            END_FRAGMENT: begin
                op = 4'($urandom_range(2));
                send_frame(1'b0, 3'($urandom), op, 1'($urandom), FORM_SHORT, 64'(len), len);
            end
            END_BAD_OPCODE: begin
                op = $urandom_range(1) ? 4'($urandom_range(7, 3)) : 4'($urandom_range(15, 11));
                send_frame(1'($urandom), 3'($urandom), op, 1'($urandom), FORM_SHORT,
                           64'(len), len);
            end
            default: begin
                // A 64-bit length with the top bit set; the frame never ends, so the
                // noise below streams out as ordinary payload.
                send_frame(1'b1, 3'd0, OP_BIN, 1'($urandom), FORM_EXT64,
                           {1'b1, 31'($urandom), 32'($urandom)}, 0);
            end
        endcase
        // After a stop these bytes are dropped without any result.
        repeat (12) send_byte(8'($urandom));
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_data_frames();
        test_control_frames();
        test_backpressure();
        test_random_stream();
        test_stop_conditions();

        s_axis_tvalid <= 1'b0;
        while (predicted_events.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fault_count == 0 && predicted_events.size() == 0) begin
            $display("[websocket_frame_deframer] OK");
        end else begin
            $display("[websocket_frame_deframer] ERROR");
        end
        $finish;
    end

endmodule
